// ===== sv/brlm_pkg.sv =====
// Package for the banded RMS level meter: types, constants and codes.
// No dependencies.
package brlm_pkg;
    localparam int LEVEL_W   = 16;
    localparam int SUM_W     = 42;
    localparam int GAIN_W    = 16;
    localparam int BSIZE_W   = 11;
    localparam int SAMPLE_W  = 16;
    localparam int DIVQ_W    = 55;   // quotient of (S << 13) / n
    localparam int ROOT_W    = 28;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;
    // ceil(2^24 / 5), exact x / 5 for x below 2^22
    localparam logic [21:0] RECIP5_Q24 = 22'd3355444;

    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_LEVEL_GAIN = 2'd1;
    localparam logic [1:0] REG_STEREO     = 2'd2;

    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_SILENT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_RD,
        ST_MUL,
        ST_SMOOTH,
        ST_WR,
        ST_OUT,
        ST_CLEAR
    } state_t;

    // close request to the math unit
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  sum;
        logic [BSIZE_W-1:0] count;
    } close_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } close_rsp_t;
endpackage

// ===== sv/brlm_rms_unit.sv =====
// Iterative divide and square root for one band close.
// Depends on brlm_pkg.
module brlm_rms_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  brlm_pkg::close_req_t   req,
    output brlm_pkg::close_rsp_t   rsp
);
    localparam int DW = brlm_pkg::DIVQ_W;
    localparam int RW = brlm_pkg::ROOT_W;

    typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT, U_DONE} ustate_t;

    ustate_t                      st_reg, st_next;
    logic [DW-1:0]                num_reg, num_next;
    logic [brlm_pkg::BSIZE_W:0]   rem_reg, rem_next;
    logic [brlm_pkg::BSIZE_W-1:0] den_reg, den_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic [DW:0]                  sv_reg, sv_next;    // sqrt radicand, shifted out two bits per step
    logic [RW-1:0]                root_reg, root_next;
    logic [DW+1:0]                sq_rem_reg, sq_rem_next;
    logic [brlm_pkg::BSIZE_W:0]   rtrial;
    logic [DW+1:0]                strial;
    logic [DW+1:0]                sshift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= U_IDLE;
        end else begin
            st_reg <= st_next;
        end
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        cnt_reg    <= cnt_next;
        sv_reg     <= sv_next;
        root_reg   <= root_next;
        sq_rem_reg <= sq_rem_next;
    end

    always_comb begin
        st_next     = st_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        cnt_next    = cnt_reg;
        sv_next     = sv_reg;
        root_next   = root_reg;
        sq_rem_next = sq_rem_reg;
        rtrial      = {rem_reg[brlm_pkg::BSIZE_W-1:0], num_reg[DW-1]};
        sshift      = {sq_rem_reg[DW-1:0], sv_reg[DW:DW-1]};
        strial      = {{(DW-RW){1'b0}}, root_reg, 2'b01};
        case (st_reg)
            U_IDLE: begin
                if (req.start) begin
                    num_next = {req.sum, 13'd0};
                    den_next = req.count;
                    rem_next = '0;
                    cnt_next = 6'(DW);
                    if (req.count == '0) begin
                        sv_next   = '0;
                        root_next = '0;
                        st_next   = U_DONE;
                    end else begin
                        st_next = U_DIV;
                    end
                end
            end
            U_DIV: begin
                if (rtrial >= {1'b0, den_reg}) begin
                    rem_next = rtrial - {1'b0, den_reg};
                    num_next = {num_reg[DW-2:0], 1'b1};
                end else begin
                    rem_next = rtrial;
                    num_next = {num_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    sv_next     = {1'b0, num_next};
                    root_next   = '0;
                    sq_rem_next = '0;
                    cnt_next    = 6'(RW);
                    st_next     = U_SQRT;
                end
            end
            U_SQRT: begin
                sv_next = {sv_reg[DW-2:0], 2'b00};
                if (sshift >= strial) begin
                    sq_rem_next = sshift - strial;
                    root_next   = {root_reg[RW-2:0], 1'b1};
                end else begin
                    sq_rem_next = sshift;
                    root_next   = {root_reg[RW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) st_next = U_DONE;
            end
            U_DONE: st_next = U_IDLE;
            default: st_next = U_IDLE;
        endcase
    end

    assign rsp.done = (st_reg == U_DONE);
    assign rsp.root = root_reg;
endmodule

// ===== sv/brlm_level_mem.sv =====
// Band level memory, one write port and one registered read port.
// Depends on brlm_pkg.
module brlm_level_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [brlm_pkg::LEVEL_W-1:0]  wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [brlm_pkg::LEVEL_W-1:0]  rdata
);
    logic [brlm_pkg::LEVEL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/banded_rms_level_meter.sv =====
// Banded RMS level meter, top level: sequencer, accumulator, output register.
// Depends on brlm_pkg, brlm_rms_unit, brlm_level_mem.
// A frame closing no band is taken one per cycle while idle; a band close with frames runs
// a 55-step divider, 28-step root, read-modify-write and output; an empty band at buffer end
// skips both. Silent packet: read, smooth, write, output per band. Write stalls on full m_.
// Reset: a clearing pass zeroes the whole level memory; s_tready low meanwhile.
module banded_rms_level_meter #(
    parameter int BAND_COUNT = 64,
    parameter int MAX_BLOCK  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_sample[15:0], right_sample[31:16]
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,   // last_in_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // band_index[5:0], band_level[21:6], zero pad
    output logic        m_tlast,   // last_update
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int AW  = $clog2(BAND_COUNT);
    localparam int BW  = AW + 1;
    localparam int LW  = brlm_pkg::LEVEL_W;
    localparam int RW  = brlm_pkg::ROOT_W;

    brlm_pkg::state_t st_reg, st_next;

    logic [brlm_pkg::BSIZE_W-1:0] bsize_reg;
    logic [brlm_pkg::GAIN_W-1:0]  gain_reg;
    logic                         stereo_reg;

    logic [brlm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [brlm_pkg::BSIZE_W-1:0] frames_reg, frames_next;
    logic [BW-1:0]                band_reg, band_next;
    logic                         silent_reg, silent_next;
    logic                         flush_reg, flush_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [RW+brlm_pkg::GAIN_W+1:0] prod_reg, prod_next;
    logic [LW-1:0]                lvl_reg, lvl_next;
    logic                         lastu_reg, lastu_next;

    logic                         ov_reg, ov_next;
    logic [AW-1:0]                oidx_reg, oidx_next;
    logic [LW-1:0]                olvl_reg, olvl_next;
    logic                         olast_reg, olast_next;

    brlm_pkg::close_req_t req;
    brlm_pkg::close_rsp_t rsp;
    logic                 mem_we;
    logic [LW-1:0]        mem_rdata;

    logic signed [15:0] l_s, r_s;
    logic [31:0]        l_sq, r_sq;
    logic [32:0]        energy;
    logic [brlm_pkg::SUM_W-1:0] sum_add;
    logic [brlm_pkg::BSIZE_W-1:0] eff, frames_inc;
    logic               accept, last_band_closing;
    logic [52:0]        num;
    logic [43:0]        qprod;
    logic [19:0]        quot;
    logic [RW+brlm_pkg::GAIN_W+3:0] p3;
    logic [17:0]        dec;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = (st_reg != brlm_pkg::ST_CLEAR);
    assign l_s = s_tdata[15:0];
    assign r_s = s_tdata[31:16];
    assign l_sq = 32'($signed(l_s) * $signed(l_s));
    assign r_sq = 32'($signed(r_s) * $signed(r_s));
    assign energy = stereo_reg ? ({1'b0, l_sq} + {1'b0, r_sq}) : {l_sq, 1'b0};
    assign sum_add = sum_reg + brlm_pkg::SUM_W'(energy);
    assign frames_inc = frames_reg + 1'b1;
    always_comb begin
        eff = bsize_reg;
        if (eff == '0) eff = brlm_pkg::BSIZE_W'(1);
        if (32'(eff) > MAX_BLOCK) eff = brlm_pkg::BSIZE_W'(MAX_BLOCK);
    end
    assign last_band_closing = (band_reg == BW'(BAND_COUNT - 1));

    // level = floor(num / (10*2^19)) = floor((num >> 20) / 5); num stays below 2^41
    assign p3    = {prod_reg, 1'b0} + (RW+brlm_pkg::GAIN_W+4)'(prod_reg);
    assign num   = 53'(p3) + {8'd0, (26'(mem_rdata) * 26'd7), 19'd0} + (53'd5 << 19);
    assign qprod = 44'(num[41:20]) * 44'(brlm_pkg::RECIP5_Q24);
    assign quot  = qprod[43:24];
    assign dec   = ({2'b0, mem_rdata} + {1'b0, mem_rdata, 1'b0}) >> 2;

    assign req.start = (st_reg == brlm_pkg::ST_DIV);
    assign req.sum   = flush_reg && (frames_reg == '0) ? '0 : sum_reg;
    assign req.count = flush_reg && (frames_reg == '0) ? '0 : frames_reg;

    brlm_rms_unit u_rms (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rsp    (rsp)
    );

    brlm_level_mem #(.DEPTH(BAND_COUNT), .AW(AW)) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(addr_reg),
        .wdata(st_reg == brlm_pkg::ST_CLEAR ? '0 : lvl_reg),
        .raddr(addr_reg),
        .rdata(mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= brlm_pkg::ST_CLEAR;
            bsize_reg  <= 11'd16;
            gain_reg   <= 16'd6144;
            stereo_reg <= 1'b1;
            sum_reg    <= '0;
            frames_reg <= '0;
            band_reg   <= '0;
            addr_reg   <= '0;
            ov_reg     <= 1'b0;
            silent_reg <= 1'b0;
            flush_reg  <= 1'b0;
        end else begin
            st_reg     <= st_next;
            sum_reg    <= sum_next;
            frames_reg <= frames_next;
            band_reg   <= band_next;
            addr_reg   <= addr_next;
            ov_reg     <= ov_next;
            silent_reg <= silent_next;
            flush_reg  <= flush_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    brlm_pkg::REG_BLOCK_SIZE: bsize_reg  <= cfg_data[10:0];
                    brlm_pkg::REG_LEVEL_GAIN: gain_reg   <= cfg_data;
                    brlm_pkg::REG_STEREO:     stereo_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
        prod_reg  <= prod_next;
        lvl_reg   <= lvl_next;
        lastu_reg <= lastu_next;
        oidx_reg  <= oidx_next;
        olvl_reg  <= olvl_next;
        olast_reg <= olast_next;
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            brlm_pkg::ST_CLEAR:
                if (addr_reg == AW'(BAND_COUNT - 1)) st_next = brlm_pkg::ST_IDLE;
            brlm_pkg::ST_IDLE:
                if (accept) begin
                    if (s_tuser == brlm_pkg::OP_SILENT) st_next = brlm_pkg::ST_RD;
                    else if (band_reg < BW'(BAND_COUNT) && frames_inc >= eff)
                        st_next = brlm_pkg::ST_DIV;
                    else if (s_tlast) begin
                        st_next = band_reg < BW'(BAND_COUNT) ? brlm_pkg::ST_DIV
                                                             : brlm_pkg::ST_IDLE;
                    end
                end
            brlm_pkg::ST_DIV:    st_next = brlm_pkg::ST_SQRT;
            brlm_pkg::ST_SQRT:   if (rsp.done) st_next = brlm_pkg::ST_MUL;
            brlm_pkg::ST_MUL:    st_next = brlm_pkg::ST_RD;
            brlm_pkg::ST_RD:     st_next = brlm_pkg::ST_SMOOTH;
            brlm_pkg::ST_SMOOTH: st_next = brlm_pkg::ST_WR;
            brlm_pkg::ST_WR:     if (!ov_reg) st_next = brlm_pkg::ST_OUT;
            brlm_pkg::ST_OUT: begin
                if (lastu_reg) st_next = brlm_pkg::ST_IDLE;
                else if (silent_reg) st_next = brlm_pkg::ST_RD;
                else st_next = brlm_pkg::ST_DIV;
            end
            default: st_next = brlm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        sum_next    = sum_reg;
        frames_next = frames_reg;
        band_next   = band_reg;
        addr_next   = addr_reg;
        silent_next = silent_reg;
        flush_next  = flush_reg;
        prod_next   = prod_reg;
        lvl_next    = lvl_reg;
        lastu_next  = lastu_reg;
        ov_next     = ov_reg && !m_tready;
        oidx_next   = oidx_reg;
        olvl_next   = olvl_reg;
        olast_next  = olast_reg;
        mem_we      = 1'b0;
        s_tready    = 1'b0;
        case (st_reg)
            brlm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            brlm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    silent_next = (s_tuser == brlm_pkg::OP_SILENT);
                    flush_next  = s_tlast;
                    addr_next   = band_reg[AW-1:0];
                    if (s_tuser == brlm_pkg::OP_SILENT) begin
                        addr_next  = '0;
                    end else begin
                        if (band_reg < BW'(BAND_COUNT)) begin
                            sum_next    = sum_add;
                            frames_next = frames_inc;
                        end
                        if (s_tlast && !(band_reg < BW'(BAND_COUNT))) begin
                            band_next   = '0;
                            sum_next    = '0;
                            frames_next = '0;
                        end
                    end
                end
            end
            brlm_pkg::ST_MUL:
                prod_next = (RW+brlm_pkg::GAIN_W+2)'(rsp.root)
                          * (RW+brlm_pkg::GAIN_W+2)'(gain_reg);
            brlm_pkg::ST_SMOOTH: begin
                if (silent_reg) lvl_next = LW'(dec);
                else lvl_next = quot > 20'(brlm_pkg::LEVEL_ONE) ? brlm_pkg::LEVEL_ONE
                                                                 : quot[LW-1:0];
                if (silent_reg) lastu_next = (addr_reg == AW'(BAND_COUNT - 1));
                else lastu_next = !flush_reg || last_band_closing;
            end
            brlm_pkg::ST_WR: begin
                if (!ov_reg) begin
                    mem_we     = 1'b1;
                    ov_next    = 1'b1;
                    oidx_next  = addr_reg;
                    olvl_next  = lvl_reg;
                    olast_next = lastu_reg;
                end
            end
            brlm_pkg::ST_OUT: begin
                addr_next = addr_reg + 1'b1;
                if (!silent_reg) begin
                    sum_next    = '0;
                    frames_next = '0;
                    band_next   = band_reg + 1'b1;
                    if (lastu_reg && flush_reg) band_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, olvl_reg, 6'(oidx_reg)};
    assign m_tlast  = olast_reg;
endmodule

// ===== sv/brlm_checker.sv =====
// Port-level checks for the banded RMS level meter, bound to the top level.
// Depends on banded_rms_level_meter ports only.
module brlm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[21:6] <= 16'd32768)
        else $error("level above 1.0");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:22] == 2'b00)
        else $error("pad bits set");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
        else $error("output word has unknown bits");
endmodule

bind banded_rms_level_meter brlm_checker u_brlm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ===== tb/banded_rms_level_meter_tb.sv =====
// Testbench for banded_rms_level_meter: directed and random frames and silent packets,
// scoreboard class predicting band levels. Depends on brlm_pkg and the RTL.
`timescale 1ns / 100ps

module banded_rms_level_meter_tb;

    localparam int BANDS = 64;
    localparam int MAXB  = 1024;

    typedef struct packed {
        logic [5:0]  band;
        logic [15:0] level;
        logic        last;
    } band_word_t;

    class level_scoreboard;
        logic [10:0] blk;
        logic [15:0] gain;
        logic        stereo;
        logic [15:0] levels[BANDS];
        logic [63:0] sum;
        int          frames;
        int          band_pos;
        band_word_t  pending[$];
        int          errors;

        function void reset_state();
            blk = 16;
            gain = 6144;
            stereo = 1;
            foreach (levels[i]) levels[i] = 0;
            sum = 0;
            frames = 0;
            band_pos = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == brlm_pkg::REG_BLOCK_SIZE) blk = val[10:0];
            else if (idx == brlm_pkg::REG_LEVEL_GAIN) gain = val;
            else if (idx == brlm_pkg::REG_STEREO) stereo = val[0];
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void close_band(int b, logic [63:0] s, int n);
            logic [63:0] rt, num, lvl;
            band_word_t w;
            rt = (n != 0) ? int_sqrt((s << 13) / n) : 0;
            num = 7 * ({48'd0, levels[b]} << 19) + 3 * rt * gain + (64'd5 << 19);
            lvl = num / (64'd10 << 19);
            if (lvl > 32768) lvl = 32768;
            levels[b] = lvl[15:0];
            w.band = b[5:0];
            w.level = lvl[15:0];
            w.last = 0;
            pending.push_back(w);
        endfunction

        function void note_input(logic op, logic signed [15:0] l, logic signed [15:0] r,
                                 logic lib);
            int eff, n_prior;
            logic [63:0] e;
            band_word_t w;
            n_prior = pending.size();
            if (op == brlm_pkg::OP_SILENT) begin
                for (int i = 0; i < BANDS; i++) begin
                    levels[i] = (3 * {2'd0, levels[i]}) >> 2;
                    w.band = i[5:0];
                    w.level = levels[i];
                    w.last = 0;
                    pending.push_back(w);
                end
            end else begin
                eff = blk;
                if (eff == 0) eff = 1;
                if (eff > MAXB) eff = MAXB;
                if (band_pos < BANDS) begin
                    if (stereo) e = 64'(l * l) + 64'(r * r);
                    else e = 2 * 64'(l * l);
                    sum += e;
                    frames++;
                    if (frames >= eff) begin
                        close_band(band_pos, sum, frames);
                        band_pos++;
                        sum = 0;
                        frames = 0;
                    end
                end
                if (lib) begin
                    if (band_pos < BANDS && frames != 0) begin
                        close_band(band_pos, sum, frames);
                        band_pos++;
                    end
                    while (band_pos < BANDS) begin
                        close_band(band_pos, 0, 0);
                        band_pos++;
                    end
                    band_pos = 0;
                    sum = 0;
                    frames = 0;
                end
            end
            if (pending.size() > n_prior) pending[pending.size()-1].last = 1;
        endfunction

        function void check_word(band_word_t got);
            band_word_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (exp.band !== got.band) begin
                $display("%0t: band exp %0d got %0d", $time, exp.band, got.band);
                errors++;
            end
            if (exp.level !== got.level) begin
                $display("%0t: level exp %0d got %0d", $time, exp.level, got.level);
                errors++;
            end
            if (exp.last !== got.last) begin
                $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // left_sample[15:0], right_sample[31:16]
    logic        s_tuser;   // operation
    logic        s_tlast;   // last_in_buffer
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // band_index[5:0], band_level[21:6], zero pad
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    level_scoreboard sb;
    int  idle_pct_in;
    int  idle_pct_out;
    bit  hold_sink;
    bit  hold_req;

    banded_rms_level_meter u_dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_word(logic op, logic [15:0] l, logic [15:0] r, logic lib);
        while ($urandom_range(99) < idle_pct_in) @(negedge aclk);
        s_tvalid = 1;
        s_tdata = {r, l};
        s_tuser = op;
        s_tlast = lib;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, l, r, lib);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_buffer(int nframes);
        for (int i = 0; i < nframes; i++)
            send_word(brlm_pkg::OP_FRAME, rand_sample(), rand_sample(), i == nframes - 1);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word({m_tdata[5:0], m_tdata[21:6], m_tlast});
    end

    always @(negedge aclk) begin
        if (hold_sink) m_tready = 0;
        else m_tready = ($urandom_range(99) >= idle_pct_out);
    end

    // receiver hold-off, counted here while the sender keeps offering words
    initial begin
        hold_sink = 0;
        wait (hold_req);
        @(negedge aclk);
        hold_sink = 1;
        repeat (3000) @(negedge aclk);
        hold_sink = 0;
    end

    initial begin
        sb = new();
        sb.reset_state();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        s_tlast = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        idle_pct_in = 0;
        idle_pct_out = 0;
        hold_req = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1;

        // directed: small bands, extremes, silent, partial/empty bands
        write_cfg(brlm_pkg::REG_BLOCK_SIZE, 1);
        send_word(brlm_pkg::OP_FRAME, 16'h8000, 16'h8000, 0);
        send_word(brlm_pkg::OP_FRAME, 16'h7fff, 16'h8000, 0);
        send_word(brlm_pkg::OP_FRAME, 16'h0000, 16'h0000, 1);
        send_word(brlm_pkg::OP_SILENT, 16'hffff, 16'hffff, 1);
        drain();
        write_cfg(brlm_pkg::REG_BLOCK_SIZE, 0);
        write_cfg(brlm_pkg::REG_LEVEL_GAIN, 16'hffff);
        write_cfg(brlm_pkg::REG_STEREO, 0);
        send_word(brlm_pkg::OP_FRAME, 16'h8000, 16'h1234, 0);
        send_word(brlm_pkg::OP_FRAME, 16'h7fff, 16'h0000, 0);
        send_word(brlm_pkg::OP_FRAME, 16'hffff, 16'h7fff, 1);
        send_word(brlm_pkg::OP_SILENT, 0, 0, 0);
        drain();
        write_cfg(brlm_pkg::REG_BLOCK_SIZE, 3);
        write_cfg(brlm_pkg::REG_LEVEL_GAIN, 0);
        write_cfg(brlm_pkg::REG_STEREO, 1);
        send_word(brlm_pkg::OP_FRAME, 16'h4000, 16'hc000, 0);
        send_word(brlm_pkg::OP_FRAME, 16'h4000, 16'hc000, 1);
        drain();
        write_cfg(brlm_pkg::REG_BLOCK_SIZE, 2047);
        write_cfg(brlm_pkg::REG_LEVEL_GAIN, 6144);
        send_word(brlm_pkg::OP_FRAME, 16'h7fff, 16'h7fff, 1);
        send_word(brlm_pkg::OP_SILENT, 0, 0, 0);
        drain();

        // frames past the last band, under a long receiver hold-off
        write_cfg(brlm_pkg::REG_BLOCK_SIZE, 1);
        idle_pct_in = 31;
        idle_pct_out = 31;
        hold_req = 1;
        send_buffer(70);
        drain();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(brlm_pkg::REG_BLOCK_SIZE,
                      (ph % 3 == 0) ? 16'd1 : 16'($urandom_range(1, 4)));
            write_cfg(brlm_pkg::REG_LEVEL_GAIN, (ph == 2) ? 16'hffff : 16'($urandom));
            write_cfg(brlm_pkg::REG_STEREO, 16'(ph[0]));
            if (ph == 4) begin
                idle_pct_in = 0;
                idle_pct_out = 0;
            end else begin
                idle_pct_in = 31;
                idle_pct_out = 31;
            end
            for (int k = 0; k < 33; k++) begin
                if ($urandom_range(29) == 0)
                    send_word(brlm_pkg::OP_SILENT, 16'($urandom), 16'($urandom),
                              1'($urandom_range(1)));
                else if ($urandom_range(9) == 0)
                    send_buffer($urandom_range(1, 6));
                else
                    send_word(brlm_pkg::OP_FRAME, rand_sample(), rand_sample(),
                              $urandom_range(15) == 0);
            end
            drain();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end
endmodule
